>>> rtl/key_matrix_debounce_6kro_report_macros.svh
// Assertion macros for the key matrix debouncer.
// Included by the checker module.
`ifndef KEY_MATRIX_DEBOUNCE_6KRO_REPORT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_6KRO_REPORT_MACROS_SVH
// Implication that holds outside reset.
`define KMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmd check failed");
// Next-cycle implication outside reset.
`define KMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmd check failed");
`endif

>>> rtl/kmd_pkg.sv
// Package for the key matrix debouncer: key states, register indexes,
// usage code table and modifier key map. No dependencies.
`default_nettype none
package kmd_pkg;
  localparam logic [1:0] ST_UP    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam logic [2:0] REG_SENSE_LEVEL   = 3'd0;
  localparam logic [2:0] REG_SHORT_THRESH  = 3'd1;
  localparam logic [2:0] REG_LONG_THRESH   = 3'd2;
  localparam logic [2:0] REG_PRESS_CEIL    = 3'd3;
  localparam logic [2:0] REG_RELEASE_THRESH = 3'd4;

  localparam int ROM_KEYS = 87;
  localparam int MAX_LINES = 8;
  localparam logic [6:0] NO_KEY = 7'd127;

  typedef logic [7:0] code_t;

  function automatic code_t usage_code(input logic [6:0] k);
    code_t t [0:ROM_KEYS-1];
    t = '{
      8'h29, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
      8'h45, 8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h2D, 8'h2E, 8'h2A, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
      8'h12, 8'h13, 8'h2F, 8'h30, 8'h31, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
      8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05,
      8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'hE0, 8'hE3, 8'hE2, 8'h2C, 8'hE6, 8'hE7,
      8'h65, 8'hE4, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h52,
      8'h50, 8'h51, 8'h4F};
    if (k < 7'(ROM_KEYS)) return t[k];
    return 8'h00;
  endfunction

  // Modifier bit for a key, or 8 when the key is not a modifier.
  function automatic logic [3:0] mod_bit(input logic [6:0] k);
    case (k)
      7'd66: return 4'd0;
      7'd54: return 4'd1;
      7'd68: return 4'd2;
      7'd67: return 4'd3;
      7'd73: return 4'd4;
      7'd65: return 4'd5;
      7'd70: return 4'd6;
      7'd71: return 4'd7;
      default: return 4'd8;
    endcase
  endfunction

  // First key of each drive line; lines past the last one start at the end.
  function automatic logic [6:0] line_start(input logic [3:0] l);
    case (l)
      4'd0: return 7'd0;
      4'd1: return 7'd13;
      4'd2: return 7'd27;
      4'd3: return 7'd41;
      4'd4: return 7'd54;
      4'd5: return 7'd66;
      4'd6: return 7'd74;
      default: return 7'd87;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/kmd_slots.sv
// Six report slots: free on release, refresh or allocate per key, build report.
// Depends on kmd_pkg.
`default_nettype none
module kmd_slots #(
  parameter int NUM_SLOTS = 6,
  parameter int KEY_W = 7
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic clear_start,
  input  wire logic key_valid,
  input  wire logic [KEY_W-1:0] key_index,
  input  wire logic [1:0] key_state,
  input  wire logic report_take,
  output logic [7:0] codes [NUM_SLOTS],
  output logic slot_busy [NUM_SLOTS],
  output logic [KEY_W-1:0] slot_keys [NUM_SLOTS]
);
  import kmd_pkg::*;

  logic busy [NUM_SLOTS];
  logic [KEY_W-1:0] kidx [NUM_SLOTS];
  code_t scode [NUM_SLOTS];
  logic [1:0] status [NUM_SLOTS];
  logic sent [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] hit, freev;
  logic [NUM_SLOTS-1:0] alloc;
  logic is_mod;

  always_comb begin
    is_mod = (mod_bit(7'(key_index)) != 4'd8);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      hit[s] = busy[s] && kidx[s] == key_index;
      freev[s] = !busy[s];
    end
    alloc = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (freev[s] && (alloc == '0) && ((freev & ((NUM_SLOTS)'(1) << s) - 1'b1) == '0))
        alloc[s] = 1'b1;
    end
  end

  // A key visited releases its slot when up; otherwise a non-modifier key refreshes or claims one.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        busy[s] <= 1'b0;
        kidx[s] <= KEY_W'(NO_KEY);
        scode[s] <= '0;
        status[s] <= ST_UP;
        sent[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (clear_start && busy[s] && kidx[s] >= KEY_W'(ROM_KEYS)) begin
          busy[s] <= 1'b0;
          kidx[s] <= KEY_W'(NO_KEY);
          scode[s] <= '0;
          status[s] <= ST_UP;
          sent[s] <= 1'b0;
        end else if (key_valid && hit[s] && key_state == ST_UP) begin
          busy[s] <= 1'b0;
          kidx[s] <= KEY_W'(NO_KEY);
          scode[s] <= '0;
          status[s] <= ST_UP;
          sent[s] <= 1'b0;
        end else if (key_valid && hit[s] && !is_mod) begin
          status[s] <= key_state;
        end else if (key_valid && key_state != ST_UP && !is_mod && hit == '0 && alloc[s]) begin
          busy[s] <= 1'b1;
          kidx[s] <= key_index;
          scode[s] <= usage_code(7'(key_index));
          status[s] <= key_state;
          sent[s] <= 1'b0;
        end else if (report_take && status[s] == ST_SHORT) begin
          sent[s] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      codes[s] = '0;
      if (status[s] == ST_LONG || (status[s] == ST_SHORT && !sent[s])) codes[s] = scode[s];
      slot_busy[s] = busy[s];
      slot_keys[s] = kidx[s];
    end
  end
endmodule
`default_nettype wire

>>> rtl/key_matrix_debounce_6kro_report.sv
// Top level of the key matrix debouncer with 6-key-rollover report.
// Depends on kmd_pkg and kmd_slots.
`default_nettype none
// A scan word is taken only in the idle state (in_stall is high otherwise), so
// a new scan word is not accepted until the last one has ended its walk and
// passed its result to the report register. The per-key counters and state
// sit in one memory with a registered read.
// Each scan first checks the keys held in the six slots (one read per busy slot,
// no write-back) so that slots of keys going up are freed before any key
// claims one; then a sequencer walks all keys, issuing one read each cycle
// and writing back the updated entry the next cycle while the slot logic
// sees that key. A key is written only once per scan, so read and write
// never collide. The report register holds the result until taken; the next
// scan may enter meanwhile, and its walk waits at the end until the report
// register is free.
module key_matrix_debounce_6kro_report #(
  parameter int NUM_KEYS = 87,
  parameter int NUM_LINES = 7,
  parameter int SENSES_PER_LINE = 14,
  parameter int NUM_SLOTS = 6,
  parameter int COUNTER_WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [13:0] line1_levels,
  input  wire logic [13:0] line2_levels,
  input  wire logic [13:0] line3_levels,
  input  wire logic [13:0] line4_levels,
  input  wire logic [13:0] line5_levels,
  input  wire logic [13:0] line6_levels,
  input  wire logic [13:0] line7_levels,
  input  wire logic cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] modifier_bits,
  output logic [7:0] report_key_a,
  output logic [7:0] report_key_b,
  output logic [7:0] report_key_c,
  output logic [7:0] report_key_d,
  output logic [7:0] report_key_e,
  output logic [7:0] report_key_f
);
  import kmd_pkg::*;

  localparam int KW = 7;
  localparam int CW = COUNTER_WIDTH;
  localparam int EW = 2 * CW + 2;
  localparam logic [CW-1:0] CMAX = '1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_PRE  = 2'd3;

  logic hit_level;
  logic [7:0] short_th, long_th, ceil_th, rel_th;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_level <= 1'b1;
      short_th <= 8'd5;
      long_th <= 8'd100;
      ceil_th <= 8'd200;
      rel_th <= 8'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SENSE_LEVEL:    hit_level <= cfg_data[0];
        REG_SHORT_THRESH:   short_th <= cfg_data;
        REG_LONG_THRESH:    long_th <= cfg_data;
        REG_PRESS_CEIL:     ceil_th <= cfg_data;
        REG_RELEASE_THRESH: rel_th <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan word as a flat sense vector per line.
  logic [15:0] lines [MAX_LINES];
  logic [1:0] state, state_next;
  logic [KW-1:0] rd_key;
  logic [KW-1:0] wb_key;
  logic wb_valid;
  logic wb_pre;
  logic [2:0] pre_idx;
  logic [KW-1:0] addr;
  logic rd_en;
  logic [3:0] line;
  logic [KW-1:0] line_pos;
  logic sense_bit;
  logic sense_use;
  logic rd_sense;
  logic rd_use;

  // Per key: {state, release counter, press counter}; unwritten keys read as zero.
  logic [EW-1:0] mem [NUM_KEYS];
  logic [EW-1:0] rd_data;
  logic [NUM_KEYS-1:0] valid;
  logic clear_start;
  logic [7:0] mods;
  logic [3:0] wb_mod;

  logic slot_busy [NUM_SLOTS];
  logic [KW-1:0] slot_keys [NUM_SLOTS];
  logic slot_key_valid;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_PRE;
      S_PRE: if (pre_idx == 3'(NUM_SLOTS - 1)) state_next = S_WALK;
      S_WALK: if (!wb_valid && rd_key == KW'(NUM_KEYS)) state_next = S_DONE;
      S_DONE: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Slot check reads the keys held in slots, the walk reads every key.
  always_comb begin
    addr = rd_key;
    rd_en = (state == S_WALK) && rd_key < KW'(NUM_KEYS);
    if (state == S_PRE) begin
      addr = slot_keys[pre_idx];
      rd_en = slot_busy[pre_idx];
    end
  end

  // Locate the current key in its line; keys outside every line keep their counters.
  always_comb begin
    line = 4'd0;
    for (int l = 1; l < MAX_LINES; l++)
      if (l < NUM_LINES && addr >= KW'(line_start(4'(l)))) line = 4'(l);
    line_pos = addr - KW'(line_start(line));
    sense_use = line_pos < KW'(SENSES_PER_LINE) && addr < KW'(line_start(line + 4'd1));
    sense_bit = 1'b0;
    if (sense_use) sense_bit = lines[line[2:0]][line_pos[3:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_key <= '0;
      pre_idx <= '0;
      wb_valid <= 1'b0;
      wb_pre <= 1'b0;
      valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wb_valid <= rd_en;
      wb_pre <= (state == S_PRE);
      if (state == S_IDLE && in_valid) pre_idx <= '0;
      else if (state == S_PRE) pre_idx <= pre_idx + 1'b1;
      if (state == S_IDLE && in_valid) rd_key <= '0;
      else if (state == S_WALK && rd_key < KW'(NUM_KEYS)) rd_key <= rd_key + 1'b1;
      else if (state == S_WALK) rd_key <= rd_key;
      if (wb_valid && !wb_pre) valid[wb_key] <= 1'b1;
      if (state == S_DONE && state_next == S_IDLE) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      lines[0] <= {2'b0, line1_levels};
      lines[1] <= {2'b0, line2_levels};
      lines[2] <= {2'b0, line3_levels};
      lines[3] <= {2'b0, line4_levels};
      lines[4] <= {2'b0, line5_levels};
      lines[5] <= {2'b0, line6_levels};
      lines[6] <= {2'b0, line7_levels};
      lines[7] <= '0;
    end
    if (rd_en) rd_data <= mem[addr];
    wb_key <= addr;
    rd_sense <= sense_bit;
    rd_use <= sense_use;
  end

  // Read-modify-write of the key entry.
  logic [CW-1:0] pc, rc, pc_n, rc_n;
  logic [1:0] ks, ks_n;
  logic [EW-1:0] wb_data;
  always_comb begin
    if (valid[wb_key]) {ks, rc, pc} = rd_data;
    else {ks, rc, pc} = '0;
    pc_n = pc;
    rc_n = rc;
    ks_n = ks;
    if (rd_use && rd_sense == hit_level) begin
      if ({{(16-CW){1'b0}}, pc} <= {8'd0, ceil_th} && pc != CMAX) pc_n = pc + 1'b1;
    end else if (rd_use) begin
      if ({{(16-CW){1'b0}}, rc} <= {8'd0, rel_th} && rc != CMAX) rc_n = rc + 1'b1;
    end
    if ({{(16-CW){1'b0}}, pc_n} >= {8'd0, long_th}) begin
      if (ks_n != ST_LONG) begin
        rc_n = '0;
        ks_n = ST_LONG;
      end
    end else if ({{(16-CW){1'b0}}, pc_n} >= {8'd0, short_th}) begin
      if (ks_n != ST_SHORT) begin
        rc_n = '0;
        ks_n = ST_SHORT;
      end
    end
    if ({{(16-CW){1'b0}}, rc_n} >= {8'd0, rel_th} && ks_n != ST_UP) begin
      pc_n = '0;
      ks_n = ST_UP;
    end
    wb_data = {ks_n, rc_n, pc_n};
  end

  always_ff @(posedge clk) begin
    if (wb_valid && !wb_pre) mem[wb_key] <= wb_data;
  end

  assign wb_mod = mod_bit(wb_key);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) mods <= '0;
    else if (wb_valid && !wb_pre && wb_mod != 4'd8 && ks_n != ST_UP)
      mods[wb_mod[2:0]] <= 1'b1;
  end

  assign clear_start = (state == S_IDLE && in_valid);
  // The slot check only frees; the walk frees, refreshes and claims.
  assign slot_key_valid = wb_valid && (!wb_pre || ks_n == ST_UP);

  logic [7:0] codes [NUM_SLOTS];
  logic take;
  assign take = (state == S_DONE && state_next == S_IDLE);

  kmd_slots #(.NUM_SLOTS(NUM_SLOTS), .KEY_W(KW)) u_slots (
    .clk(clk), .rst(rst), .clear_start(clear_start), .key_valid(slot_key_valid),
    .key_index(wb_key), .key_state(ks_n), .report_take(take), .codes(codes),
    .slot_busy(slot_busy), .slot_keys(slot_keys)
  );

  logic [7:0] rep [6];
  always_ff @(posedge clk) begin
    if (take) begin
      modifier_bits <= mods;
      for (int s = 0; s < 6; s++) rep[s] <= (s < NUM_SLOTS) ? codes[s] : 8'd0;
    end
  end
  assign report_key_a = rep[0];
  assign report_key_b = rep[1];
  assign report_key_c = rep[2];
  assign report_key_d = rep[3];
  assign report_key_e = rep[4];
  assign report_key_f = rep[5];
endmodule
`default_nettype wire

>>> rtl/kmd_checker.sv
// Port-level checker for the key matrix debouncer, bound to the top level.
// Depends on key_matrix_debounce_6kro_report_macros.svh.
`default_nettype none
`include "key_matrix_debounce_6kro_report_macros.svh"
module kmd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] modifier_bits
);
  // A scan word accepted leads to a slot check: input stalls next cycle.
  `KMD_ASSERT_NEXT(a_walk_busy, in_valid && !in_stall, in_stall)
  // Stalled report word holds.
  `KMD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(modifier_bits))
  // A new report never appears while input is idle and accepting.
  `KMD_ASSERT_IMP(a_no_spont, $rose(out_valid), $past(in_stall))
endmodule
bind key_matrix_debounce_6kro_report kmd_checker u_kmd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .modifier_bits(modifier_bits)
);
`default_nettype wire
